### hw/rtl/imhq_pkg.sv
// ----------------------------------------------------------------------------
// imhq_pkg
// Shared widths, codes and memory request types of the indexed min-heap queue.
// ----------------------------------------------------------------------------
package imhq_pkg;

    localparam int CAPACITY  = 1024;
    localparam int KEY_W     = 31;
    localparam int VTX_W     = 10;
    localparam int VTX_DEPTH = 1 << VTX_W;
    localparam int SLOT_W    = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        CMD_INSERT  = 2'd0,
        CMD_EXTRACT = 2'd1,
        CMD_DECR    = 2'd2,
        CMD_PEEK    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_INCREASE  = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    // one heap slot
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VTX_W-1:0] vtx;
    } t_hent;

    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] waddr;
        t_hent             wdata;
        logic [SLOT_W-1:0] raddr;
    } t_hreq;

    // one vertex table entry
    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [VTX_W-1:0]  pred;
        logic              has;
    } t_vent;

    typedef struct packed {
        logic              we_slot;
        logic              we_pred;
        logic              we_has;
        logic [VTX_W-1:0]  waddr;
        t_vent             wdata;
        logic [VTX_W-1:0]  raddr;
    } t_vreq;

endpackage

### hw/rtl/indexed_min_heap_queue.sv
// ----------------------------------------------------------------------------
// indexed_min_heap_queue
// Indexed binary min-heap with insert, extract, decrease key and peek.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its single result
// appears on the o_ ports for one cycle with o_valid and cannot be held off.
// Insert, and extract or peek on an empty heap, answer straight from idle;
// peek and extract on a non-empty heap first read the root, then the last
// slot and the root's vertex entry; decrease key reads the vertex table,
// answers underflow when the vertex's slot is at or beyond the count, and
// else reads the heap slot first. The heap memory has one read port, so a
// sift step up reads the parent and compares, a step down reads the left
// and the right child and compares, and a write-back state ends the sift.
// A result may be shown before its sift has finished; busy covers the rest.
module indexed_min_heap_queue (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  i_command,
    input  logic [imhq_pkg::VTX_W-1:0]  i_vertex_id,
    input  logic [imhq_pkg::KEY_W-1:0]  i_key,
    input  logic [imhq_pkg::VTX_W-1:0]  i_predecessor_id,
    output logic                        o_valid,
    output logic [1:0]                  o_status,
    output logic [imhq_pkg::VTX_W-1:0]  o_out_vertex,
    output logic [imhq_pkg::KEY_W-1:0]  o_out_key,
    output logic [imhq_pkg::VTX_W-1:0]  o_out_predecessor,
    output logic                        o_predecessor_valid,
    output logic [imhq_pkg::CNT_W-1:0]  o_entry_count
);
    import imhq_pkg::*;

    localparam int CW = SLOT_W + 2;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_XROOT  = 11'b000_0000_0010,
        S_XLAST  = 11'b000_0000_0100,
        S_DVT    = 11'b000_0000_1000,
        S_DHP    = 11'b000_0001_0000,
        S_SURD   = 11'b000_0010_0000,
        S_SUCMP  = 11'b000_0100_0000,
        S_SDRL   = 11'b000_1000_0000,
        S_SDRR   = 11'b001_0000_0000,
        S_SDCMP  = 11'b010_0000_0000,
        S_FIN    = 11'b100_0000_0000
    } t_state;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [SLOT_W-1:0] r_s, n_s;
    logic [SLOT_W-1:0] r_p, n_p;
    t_hent             r_cur, n_cur;
    t_hent             r_left, n_left;
    logic              r_cmd_peek, n_cmd_peek;
    logic [VTX_W-1:0]  r_vid, n_vid;
    logic [VTX_W-1:0]  r_pid, n_pid;
    logic [KEY_W-1:0]  r_key, n_key;
    t_hent             r_root, n_root;

    logic              n_valid;
    logic [1:0]        n_status;
    logic [VTX_W-1:0]  n_ov;
    logic [KEY_W-1:0]  n_ok;
    logic [VTX_W-1:0]  n_op;
    logic              n_opv;

    t_hreq hreq;
    t_hent hdata;
    t_vreq vreq;
    t_vent vdata;

    logic [CW-1:0] cnt_x, l_x, r_x;
    logic          l_in, r_in;

    imhq_heap_ram u_heap (.i_clk(i_clk), .i_req(hreq), .o_rdata(hdata));
    imhq_vertex_ram u_vtab (.i_clk(i_clk), .i_req(vreq), .o_rdata(vdata));

    // child positions for sift down
    assign cnt_x = CW'(r_cnt);
    assign l_x   = {1'b0, r_s, 1'b1};
    assign r_x   = l_x + CW'(1);
    assign l_in  = l_x < cnt_x;
    assign r_in  = r_x < cnt_x;

    assign busy = (r_state != S_IDLE);

    // sequence each request through the memories
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_s        = r_s;
        n_p        = r_p;
        n_cur      = r_cur;
        n_left     = r_left;
        n_cmd_peek = r_cmd_peek;
        n_vid      = r_vid;
        n_pid      = r_pid;
        n_key      = r_key;
        n_root     = r_root;
        n_valid    = 1'b0;
        n_status   = ST_OK;
        n_ov       = '0;
        n_ok       = '0;
        n_op       = '0;
        n_opv      = 1'b0;
        hreq       = '0;
        vreq       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_vid = i_vertex_id;
                    n_pid = i_predecessor_id;
                    n_key = i_key;
                    n_cmd_peek = (t_cmd'(i_command) == CMD_PEEK);
                    unique case (t_cmd'(i_command))
                        CMD_INSERT: begin
                            n_valid = 1'b1;
                            if (CW'(r_cnt) >= CW'(CAPACITY)) begin
                                n_status = ST_FULL;
                            end else begin
                                vreq.we_has     = 1'b1;
                                vreq.waddr      = i_vertex_id;
                                vreq.wdata.has  = 1'b0;
                                n_s     = SLOT_W'(r_cnt);
                                n_cnt   = r_cnt + CNT_W'(1);
                                n_cur   = '{key: i_key, vtx: i_vertex_id};
                                n_state = S_SURD;
                            end
                        end
                        CMD_EXTRACT, CMD_PEEK: begin
                            if (r_cnt == '0) begin
                                n_valid  = 1'b1;
                                n_status = ST_UNDERFLOW;
                            end else begin
                                hreq.raddr = '0;
                                n_state    = S_XROOT;
                            end
                        end
                        CMD_DECR: begin
                            vreq.raddr = i_vertex_id;
                            n_state    = S_DVT;
                        end
                    endcase
                end
            end
            S_XROOT: begin
                n_root     = hdata;
                vreq.raddr = hdata.vtx;
                hreq.raddr = SLOT_W'(r_cnt - CNT_W'(1));
                n_state    = S_XLAST;
            end
            S_XLAST: begin
                n_valid = 1'b1;
                n_ov    = r_root.vtx;
                n_ok    = r_root.key;
                n_op    = vdata.pred;
                n_opv   = vdata.has;
                n_state = S_IDLE;
                if (!r_cmd_peek) begin
                    n_cnt = r_cnt - CNT_W'(1);
                    if (r_cnt != CNT_W'(1)) begin
                        n_cur   = hdata;
                        n_s     = '0;
                        n_state = S_SDRL;
                    end
                end
            end
            S_DVT: begin
                if (CW'(vdata.slot) >= cnt_x) begin
                    n_valid  = 1'b1;
                    n_status = ST_UNDERFLOW;
                    n_state  = S_IDLE;
                end else begin
                    n_s        = vdata.slot;
                    hreq.raddr = vdata.slot;
                    n_state    = S_DHP;
                end
            end
            S_DHP: begin
                n_valid = 1'b1;
                n_state = S_IDLE;
                if (hdata.vtx != r_vid) begin
                    n_status = ST_UNDERFLOW;
                end else if (r_key > hdata.key) begin
                    n_status = ST_INCREASE;
                end else begin
                    vreq.we_pred    = 1'b1;
                    vreq.we_has     = 1'b1;
                    vreq.waddr      = r_vid;
                    vreq.wdata.pred = r_pid;
                    vreq.wdata.has  = 1'b1;
                    n_cur   = '{key: r_key, vtx: r_vid};
                    n_state = S_SURD;
                end
            end
            S_SURD: begin
                if (r_s == '0) begin
                    n_state = S_FIN;
                end else begin
                    n_p        = (r_s - SLOT_W'(1)) >> 1;
                    hreq.raddr = (r_s - SLOT_W'(1)) >> 1;
                    n_state    = S_SUCMP;
                end
            end
            S_SUCMP: begin
                if (hdata.key > r_cur.key) begin
                    // move parent down into the hole
                    hreq.we         = 1'b1;
                    hreq.waddr      = r_s;
                    hreq.wdata      = hdata;
                    vreq.we_slot    = 1'b1;
                    vreq.waddr      = hdata.vtx;
                    vreq.wdata.slot = r_s;
                    n_s     = r_p;
                    n_state = S_SURD;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_SDRL: begin
                if (!l_in) begin
                    n_state = S_FIN;
                end else begin
                    hreq.raddr = SLOT_W'(l_x);
                    n_state    = S_SDRR;
                end
            end
            S_SDRR: begin
                n_left     = hdata;
                hreq.raddr = SLOT_W'(r_x);
                n_state    = S_SDCMP;
            end
            S_SDCMP: begin
                n_state = S_FIN;
                if (r_in && hdata.key < r_left.key && hdata.key < r_cur.key) begin
                    hreq.we         = 1'b1;
                    hreq.waddr      = r_s;
                    hreq.wdata      = hdata;
                    vreq.we_slot    = 1'b1;
                    vreq.waddr      = hdata.vtx;
                    vreq.wdata.slot = r_s;
                    n_s     = SLOT_W'(r_x);
                    n_state = S_SDRL;
                end else if (r_left.key < r_cur.key) begin
                    hreq.we         = 1'b1;
                    hreq.waddr      = r_s;
                    hreq.wdata      = r_left;
                    vreq.we_slot    = 1'b1;
                    vreq.waddr      = r_left.vtx;
                    vreq.wdata.slot = r_s;
                    n_s     = SLOT_W'(l_x);
                    n_state = S_SDRL;
                end
            end
            S_FIN: begin
                // drop the sifted entry into its final slot
                hreq.we         = 1'b1;
                hreq.waddr      = r_s;
                hreq.wdata      = r_cur;
                vreq.we_slot    = 1'b1;
                vreq.waddr      = r_cur.vtx;
                vreq.wdata.slot = r_s;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            o_valid <= n_valid;
        end
    end

    // working registers and result
    always_ff @(posedge i_clk) begin
        r_s        <= n_s;
        r_p        <= n_p;
        r_cur      <= n_cur;
        r_left     <= n_left;
        r_cmd_peek <= n_cmd_peek;
        r_vid      <= n_vid;
        r_pid      <= n_pid;
        r_key      <= n_key;
        r_root     <= n_root;
        if (n_valid) begin
            o_status            <= n_status;
            o_out_vertex        <= n_ov;
            o_out_key           <= n_ok;
            o_out_predecessor   <= n_op;
            o_predecessor_valid <= n_opv;
            o_entry_count       <= n_cnt;
        end
    end

endmodule

### hw/rtl/imhq_heap_ram.sv
// ----------------------------------------------------------------------------
// imhq_heap_ram
// Heap slot store: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module imhq_heap_ram (
    input  logic           i_clk,
    input  imhq_pkg::t_hreq i_req,
    output imhq_pkg::t_hent o_rdata
);
    import imhq_pkg::*;

    t_hent r_mem [CAPACITY];

    // write request, registered read
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        o_rdata <= r_mem[i_req.raddr];
    end

endmodule

### hw/rtl/imhq_vertex_ram.sv
// ----------------------------------------------------------------------------
// imhq_vertex_ram
// Per-vertex table of heap slot and predecessor, written field by field.
// ----------------------------------------------------------------------------
module imhq_vertex_ram (
    input  logic           i_clk,
    input  imhq_pkg::t_vreq i_req,
    output imhq_pkg::t_vent o_rdata
);
    import imhq_pkg::*;

    t_vent r_mem [VTX_DEPTH];

    // field writes, registered read
    always_ff @(posedge i_clk) begin
        if (i_req.we_slot) begin
            r_mem[i_req.waddr].slot <= i_req.wdata.slot;
        end
        if (i_req.we_pred) begin
            r_mem[i_req.waddr].pred <= i_req.wdata.pred;
        end
        if (i_req.we_has) begin
            r_mem[i_req.waddr].has <= i_req.wdata.has;
        end
        o_rdata <= r_mem[i_req.raddr];
    end

endmodule

### hw/rtl/imhq_checker.sv
// ----------------------------------------------------------------------------
// imhq_checker
// Port-level checks of the indexed min-heap queue, bound to the top level.
// ----------------------------------------------------------------------------
module imhq_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        o_valid,
    input logic [1:0]                  o_status,
    input logic [imhq_pkg::VTX_W-1:0]  o_out_vertex,
    input logic [imhq_pkg::KEY_W-1:0]  o_out_key,
    input logic [imhq_pkg::CNT_W-1:0]  o_entry_count
);
    import imhq_pkg::*;

    // an accepted request either answers at once or keeps the block busy
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> o_valid || busy)
        else $error("request neither answered nor in progress");

    // a rejected request returns no entry
    a_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> o_out_vertex == '0 && o_out_key == '0)
        else $error("rejected request carries data");

    // full is reported only with a full heap
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_FULL |-> o_entry_count == CNT_W'(CAPACITY))
        else $error("full reported below capacity");

    // the reported count never exceeds the capacity
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_entry_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // reset leaves the block idle and silent
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !busy && !o_valid)
        else $error("block not idle after reset");

endmodule

bind indexed_min_heap_queue imhq_checker u_imhq_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_valid      (o_valid),
    .o_status     (o_status),
    .o_out_vertex (o_out_vertex),
    .o_out_key    (o_out_key),
    .o_entry_count(o_entry_count)
);

### bench/indexed_min_heap_queue_tb.sv
// ----------------------------------------------------------------------------
// indexed_min_heap_queue_tb
// Self-checking bench for the indexed min-heap queue: a directed table of
// requests covering empty, tie and key-increase cases, then random request
// streams with a fill to capacity and inserts on the full heap, all scored
// against an in-bench heap model of slots, vertex positions and predecessors.
// ----------------------------------------------------------------------------
module indexed_min_heap_queue_tb;
    import imhq_pkg::*;

    typedef struct {
        t_status          status;
        logic [VTX_W-1:0] vtx;
        logic [KEY_W-1:0] key;
        logic [VTX_W-1:0] pred;
        logic             pred_known;
        logic             pred_valid;
        logic [CNT_W-1:0] count;
    } t_answer;

    typedef struct {
        t_cmd             cmd;
        logic [VTX_W-1:0] vtx;
        logic [KEY_W-1:0] key;
        logic [VTX_W-1:0] pred;
        bit               typed;
        t_status          status;
        int               count;
    } t_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [1:0]           i_command = '0;
    logic [VTX_W-1:0]     i_vertex_id = '0;
    logic [KEY_W-1:0]     i_key = '0;
    logic [VTX_W-1:0]     i_predecessor_id = '0;
    logic                 o_valid;
    logic [1:0]           o_status;
    logic [VTX_W-1:0]     o_out_vertex;
    logic [KEY_W-1:0]     o_out_key;
    logic [VTX_W-1:0]     o_out_predecessor;
    logic                 o_predecessor_valid;
    logic [CNT_W-1:0]     o_entry_count;

    // heap image kept by the bench
    logic [KEY_W-1:0]     heap_key  [CAPACITY];
    logic [VTX_W-1:0]     heap_vtx  [CAPACITY];
    logic [SLOT_W-1:0]    vtx_slot  [VTX_DEPTH];
    logic [VTX_W-1:0]     vtx_pred  [VTX_DEPTH];
    bit                   vtx_has   [VTX_DEPTH];
    bit                   pred_seen [VTX_DEPTH];
    bit                   ever_in   [VTX_DEPTH];
    int                   model_fill = 0;
    int                   inserted_vtx [$];

    t_answer              pending_answers [$];
    int                   mismatches = 0;
    int                   requests = 0;
    int                   answers = 0;
    int                   full_hits = 0;
    int                   calm_from = 0;
    int                   calm_to = 0;

    always #4 i_clk = ~i_clk;

    indexed_min_heap_queue u_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .busy                (busy),
        .i_command           (i_command),
        .i_vertex_id         (i_vertex_id),
        .i_key               (i_key),
        .i_predecessor_id    (i_predecessor_id),
        .o_valid             (o_valid),
        .o_status            (o_status),
        .o_out_vertex        (o_out_vertex),
        .o_out_key           (o_out_key),
        .o_out_predecessor   (o_out_predecessor),
        .o_predecessor_valid (o_predecessor_valid),
        .o_entry_count       (o_entry_count)
    );

    task automatic swap_entries(input int a, input int b);
        logic [KEY_W-1:0] k;
        logic [VTX_W-1:0] v;
        k = heap_key[a];
        v = heap_vtx[a];
        heap_key[a] = heap_key[b];
        heap_vtx[a] = heap_vtx[b];
        heap_key[b] = k;
        heap_vtx[b] = v;
        vtx_slot[heap_vtx[a]] = SLOT_W'(a);
        vtx_slot[heap_vtx[b]] = SLOT_W'(b);
    endtask

    task automatic bubble_up(input int s);
        int p;
        while (s > 0) begin
            p = (s - 1) / 2;
            if (!(heap_key[p] > heap_key[s]))
                break;
            swap_entries(s, p);
            s = p;
        end
    endtask

    task automatic bubble_down(input int s);
        int l, r, low;
        forever begin
            l = 2 * s + 1;
            r = 2 * s + 2;
            low = s;
            if (l < model_fill && heap_key[l] < heap_key[low])
                low = l;
            if (r < model_fill && heap_key[r] < heap_key[low])
                low = r;
            if (low == s)
                break;
            swap_entries(s, low);
            s = low;
        end
    endtask

    // apply one request to the heap image and return its answer
    task automatic apply_request(input t_cmd cmd, input logic [VTX_W-1:0] v,
                                 input logic [KEY_W-1:0] k, input logic [VTX_W-1:0] p,
                                 output t_answer a);
        int s;
        logic [VTX_W-1:0] top;
        a = '{ST_OK, '0, '0, '0, 1'b1, 1'b0, '0};
        case (cmd)
            CMD_INSERT: begin
                if (model_fill >= CAPACITY) begin
                    a.status = ST_FULL;
                    full_hits++;
                end else begin
                    s = model_fill;
                    heap_key[s] = k;
                    heap_vtx[s] = v;
                    vtx_slot[v] = SLOT_W'(s);
                    vtx_has[v] = 1'b0;
                    model_fill++;
                    if (!ever_in[v])
                        inserted_vtx.push_back(v);
                    ever_in[v] = 1'b1;
                    bubble_up(s);
                end
            end
            CMD_EXTRACT, CMD_PEEK: begin
                if (model_fill == 0) begin
                    a.status = ST_UNDERFLOW;
                end else begin
                    top = heap_vtx[0];
                    a.vtx = top;
                    a.key = heap_key[0];
                    a.pred = vtx_pred[top];
                    a.pred_known = pred_seen[top];
                    a.pred_valid = vtx_has[top];
                    if (cmd == CMD_EXTRACT) begin
                        model_fill--;
                        if (model_fill > 0) begin
                            heap_key[0] = heap_key[model_fill];
                            heap_vtx[0] = heap_vtx[model_fill];
                            vtx_slot[heap_vtx[0]] = '0;
                            bubble_down(0);
                        end
                    end
                end
            end
            default: begin
                s = vtx_slot[v];
                if (s >= model_fill || heap_vtx[s] != v) begin
                    a.status = ST_UNDERFLOW;
                end else if (k > heap_key[s]) begin
                    a.status = ST_INCREASE;
                end else begin
                    heap_key[s] = k;
                    vtx_pred[v] = p;
                    vtx_has[v] = 1'b1;
                    pred_seen[v] = 1'b1;
                    bubble_up(s);
                end
            end
        endcase
        a.count = CNT_W'(model_fill);
    endtask

    // drive one request, hold it until taken, then record its answer
    task automatic issue(input t_row r);
        t_answer a;
        int gap;
        gap = 0;
        if (!(requests >= calm_from && requests < calm_to) && $urandom_range(99) < 35)
            gap = $urandom_range(4, 1);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_command <= r.cmd;
        i_vertex_id <= r.vtx;
        i_key <= r.key;
        i_predecessor_id <= r.pred;
        do @(posedge i_clk); while (busy);
        apply_request(r.cmd, r.vtx, r.key, r.pred, a);
        if (r.typed) begin
            a.status = r.status;
            a.count = CNT_W'(r.count);
        end
        pending_answers.push_back(a);
        requests++;
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        case ($urandom_range(2))
            0: pick_key = KEY_W'($urandom_range(15));
            1: pick_key = KEY_W'($urandom_range(4095));
            default: pick_key = KEY_W'($urandom);
        endcase
    endfunction

    function automatic logic [VTX_W-1:0] pick_vtx();
        if ($urandom_range(1))
            pick_vtx = VTX_W'($urandom_range(63));
        else
            pick_vtx = VTX_W'($urandom);
    endfunction

    // one random request, biased toward known vertices for decrease key
    function automatic t_row random_row();
        t_row r;
        int sel;
        int s;
        r = '{CMD_INSERT, pick_vtx(), pick_key(), VTX_W'($urandom), 1'b0, ST_OK, 0};
        sel = $urandom_range(99);
        if (sel < 35)
            r.cmd = CMD_INSERT;
        else if (sel < 60)
            r.cmd = CMD_EXTRACT;
        else if (sel < 70)
            r.cmd = CMD_PEEK;
        else if (inserted_vtx.size() > 0) begin
            r.cmd = CMD_DECR;
            r.vtx = VTX_W'(inserted_vtx[$urandom_range(inserted_vtx.size() - 1)]);
            s = vtx_slot[r.vtx];
            if (s < model_fill && heap_vtx[s] == r.vtx) begin
                case ($urandom_range(3))
                    0: r.key = heap_key[s];
                    1: r.key = KEY_W'(heap_key[s] + 1 + $urandom_range(7));
                    default: r.key = heap_key[s] -
                                     KEY_W'($urandom_range(heap_key[s] % 50));
                endcase
                if (r.key > heap_key[s] && heap_key[s] == {KEY_W{1'b1}})
                    r.key = heap_key[s];
            end
        end else
            r.cmd = CMD_PEEK;
        return r;
    endfunction

    // score each answer against the oldest expectation
    always @(posedge i_clk) begin
        t_answer e;
        if (i_rst_n && o_valid) begin
            answers++;
            if (pending_answers.size() == 0) begin
                $error("answer with none expected: status %0d", o_status);
                mismatches++;
            end else begin
                e = pending_answers.pop_front();
                if (o_status !== e.status) begin
                    $error("status expected %0d actual %0d", e.status, o_status);
                    mismatches++;
                end
                if (o_out_vertex !== e.vtx) begin
                    $error("out_vertex expected %0d actual %0d", e.vtx, o_out_vertex);
                    mismatches++;
                end
                if (o_out_key !== e.key) begin
                    $error("out_key expected %0d actual %0d", e.key, o_out_key);
                    mismatches++;
                end
                if (e.pred_known && o_out_predecessor !== e.pred) begin
                    $error("out_predecessor expected %0d actual %0d",
                           e.pred, o_out_predecessor);
                    mismatches++;
                end
                if (o_predecessor_valid !== e.pred_valid) begin
                    $error("predecessor_valid expected %0d actual %0d",
                           e.pred_valid, o_predecessor_valid);
                    mismatches++;
                end
                if (o_entry_count !== e.count) begin
                    $error("entry_count expected %0d actual %0d", e.count, o_entry_count);
                    mismatches++;
                end
            end
        end
    end

    // directed requests: typed rows carry status and count known by inspection
    t_row directed [] = '{
        '{CMD_PEEK,    10'd0,    31'd0,          10'd0,    1, ST_UNDERFLOW, 0},
        '{CMD_EXTRACT, 10'd0,    31'd0,          10'd0,    1, ST_UNDERFLOW, 0},
        '{CMD_INSERT,  10'd1023, 31'h7fffffff,   10'd1023, 1, ST_OK,        1},
        '{CMD_INSERT,  10'd0,    31'd0,          10'd0,    1, ST_OK,        2},
        '{CMD_PEEK,    10'd0,    31'd0,          10'd0,    0, ST_OK,        0},
        '{CMD_DECR,    10'd1023, 31'h7fffffff,   10'd512,  1, ST_OK,        2},
        '{CMD_DECR,    10'd1023, 31'h7ffffffe,   10'd1023, 1, ST_OK,        2},
        '{CMD_DECR,    10'd1023, 31'h7fffffff,   10'd5,    1, ST_INCREASE,  2},
        '{CMD_DECR,    10'd1023, 31'd0,          10'd341,  1, ST_OK,        2},
        '{CMD_PEEK,    10'd0,    31'd0,          10'd0,    0, ST_OK,        0},
        '{CMD_INSERT,  10'd0,    31'd7,          10'd682,  1, ST_OK,        3},
        '{CMD_INSERT,  10'd682,  31'h55555555,   10'd0,    1, ST_OK,        4},
        '{CMD_INSERT,  10'd341,  31'h2aaaaaaa,   10'd0,    1, ST_OK,        5},
        '{CMD_DECR,    10'd341,  31'd7,          10'd1023, 1, ST_OK,        5},
        '{CMD_EXTRACT, 10'd0,    31'd0,          10'd0,    0, ST_OK,        0},
        '{CMD_EXTRACT, 10'd0,    31'd0,          10'd0,    0, ST_OK,        0},
        '{CMD_EXTRACT, 10'd0,    31'd0,          10'd0,    0, ST_OK,        0},
        '{CMD_EXTRACT, 10'd0,    31'd0,          10'd0,    0, ST_OK,        0},
        '{CMD_EXTRACT, 10'd0,    31'd0,          10'd0,    0, ST_OK,        0},
        '{CMD_DECR,    10'd0,    31'd0,          10'd1,    1, ST_UNDERFLOW, 0},
        '{CMD_EXTRACT, 10'd0,    31'd0,          10'd0,    1, ST_UNDERFLOW, 0}
    };

    initial begin
        t_row r;
        int wait_cycles;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i])
            issue(directed[i]);

        // mixed traffic, with one stretch of back-to-back requests
        calm_from = requests + 50;
        calm_to = requests + 150;
        repeat (200)
            issue(random_row());

        // fill to capacity, push against the full heap, then drain a little
        while (model_fill < CAPACITY) begin
            r = random_row();
            r.cmd = CMD_INSERT;
            issue(r);
        end
        repeat (4) begin
            r = random_row();
            r.cmd = CMD_INSERT;
            issue(r);
        end
        repeat (50)
            issue(random_row());
        repeat (30) begin
            r = random_row();
            r.cmd = CMD_EXTRACT;
            issue(r);
        end
        start <= 1'b0;

        // let the last answer land and the final sift settle
        wait_cycles = 0;
        while ((pending_answers.size() > 0 || busy) && wait_cycles < 1000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (40) @(posedge i_clk);
        if (pending_answers.size() > 0) begin
            $error("%0d answers never arrived", pending_answers.size());
            mismatches++;
        end

        $display("ran %0d requests, scored %0d answers, %0d inserts refused on a full heap",
                 requests, answers, full_hits);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // hard stop if the block hangs
    initial begin
        #4000000;
        $display("timeout waiting on the block");
        $display("end of test: mismatches");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/imhq_pkg.sv
hw/rtl/imhq_heap_ram.sv
hw/rtl/imhq_vertex_ram.sv
hw/rtl/indexed_min_heap_queue.sv
hw/rtl/imhq_checker.sv
bench/indexed_min_heap_queue_tb.sv
